// File: src/tbl_pkg.sv
// Package for the two-level token bucket limiter.
// Holds widths, register indexes, status codes and the controller command struct.
`timescale 1ns / 1ps
package tbl_pkg;
   localparam int TABLE_ENTRIES_DEF    = 16;
   localparam int FRAC_BITS_DEF        = 16;
   localparam int AGGRESSIVE_LIMIT_DEF = 3;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_GCAP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CCAP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CRATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE  = 3'd4;

   localparam logic [2:0] ST_ALLOWED    = 3'd0;
   localparam logic [2:0] ST_GLOBAL     = 3'd1;
   localparam logic [2:0] ST_CLIENT     = 3'd2;
   localparam logic [2:0] ST_AGGRESSIVE = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_CLEANUP    = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic global_op; // refill and charge global bucket, look up table
      logic client_op; // refill and charge client entry
      logic sweep;     // examine one entry for cleanup
      logic sweep_clr; // start of sweep
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_cleanup;
      logic global_ok;
      logic have_slot;
      logic sweep_last;
   } sts_type;
endpackage

// File: src/tbl_ctrl.sv
// Controller state machine for the limiter.
// Uses tbl_pkg command and status structs; drives handshakes.
`timescale 1ns / 1ps
module tbl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  tbl_pkg::sts_type sts,
   output tbl_pkg::cmd_type cmd,
   output logic             rsp_load
);
   import tbl_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_GLOBAL = 3'd1;
   localparam logic [2:0] S_CLIENT = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, accept, finish;

   // output register is free when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      finish    = 1'b0;
      cmd.load  = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_GLOBAL;
         end
         S_GLOBAL: begin
            if (sts.is_cleanup) begin
               cmd.sweep_clr = 1'b1;
               state_in = S_SWEEP;
            end else if (sts.global_ok && sts.have_slot) begin
               cmd.global_op = 1'b1;
               state_in = S_CLIENT;
            end else if (out_free) begin
               cmd.global_op = 1'b1;
               finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CLIENT: begin
            if (out_free) begin
               cmd.client_op = 1'b1;
               finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SWEEP: begin
            if (!sts.sweep_last) begin
               cmd.sweep = 1'b1;
            end else if (out_free) begin
               cmd.sweep = 1'b1;
               finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_load = finish;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// File: src/tbl_dpath.sv
// Datapath: configuration registers, global bucket, client table and result register.
// Uses tbl_pkg command and status structs and result codes.
`timescale 1ns / 1ps
module tbl_dpath #(
   parameter int TABLE_ENTRIES    = tbl_pkg::TABLE_ENTRIES_DEF,
   parameter int FRAC_BITS        = tbl_pkg::FRAC_BITS_DEF,
   parameter int AGGRESSIVE_LIMIT = tbl_pkg::AGGRESSIVE_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tbl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbl_pkg::CSR_DAT_W-1:0]    csr_data,
   input  logic                             req_req_type,
   input  logic [31:0]                      req_client_addr,
   input  logic [31:0]                      req_now_time,
   input  tbl_pkg::cmd_type                 cmd,
   input  logic                             rsp_load,
   output tbl_pkg::sts_type                 sts,
   output logic                             rsp_allowed,
   output logic [2:0]                       rsp_status,
   output logic [4:0]                       rsp_removed_count
);
   import tbl_pkg::*;

   localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TW  = 16 + FRAC_BITS + 1;  // token width with headroom
   localparam int PW  = 32 + 24;             // elapsed times rate
   localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

   // configuration
   logic [15:0] gcap_ff, ccap_ff;
   logic [23:0] grate_ff, crate_ff;
   logic [31:0] idle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gcap_ff  <= 16'd1000;
         grate_ff <= 24'd65536;
         ccap_ff  <= 16'd10;
         crate_ff <= 24'd65536;
         idle_ff  <= 32'd60000000;
      end else if (csr_we) begin
         case (csr_index)
            REG_GCAP:  gcap_ff  <= csr_data[15:0];
            REG_GRATE: grate_ff <= csr_data[23:0];
            REG_CCAP:  ccap_ff  <= csr_data[15:0];
            REG_CRATE: crate_ff <= csr_data[23:0];
            REG_IDLE:  idle_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // captured item
   logic        type_ff;
   logic [31:0] addr_ff, now_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_req_type;
         addr_ff <= req_client_addr;
         now_ff  <= req_now_time;
      end
   end

   // table storage
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [31:0]   eaddr_ff [TABLE_ENTRIES];
   logic [TW-1:0] etok_ff  [TABLE_ENTRIES];
   logic [31:0]   etime_ff [TABLE_ENTRIES];
   logic [7:0]    eblk_ff  [TABLE_ENTRIES];

   // global bucket state
   logic [TW-1:0] gtok_ff;
   logic [31:0]   glast_ff;

   // refill: clamp(tokens + elapsed*rate, cap<<F)
   function automatic logic [TW-1:0] refill(input logic [TW-1:0] tok,
         input logic [31:0] el, input logic [23:0] rate, input logic [15:0] cap);
      logic [PW-1:0]   prod;
      logic [PW:0]     sum;
      logic [TW-1:0]   lim;
      prod = el * rate;
      sum  = {1'b0, prod} + (PW+1)'(tok);
      lim  = TW'(cap) << FRAC_BITS;
      refill = (sum > (PW+1)'(lim)) ? lim : sum[TW-1:0];
   endfunction

   // global step: refill, lookup, free slot search
   logic [TW-1:0] gref;
   logic          hit;
   logic [IW-1:0] hit_idx, free_idx, slot_idx;
   logic          have_free;
   assign gref = refill(gtok_ff, now_ff - glast_ff, grate_ff, gcap_ff);

   always_comb begin
      hit = 1'b0; hit_idx = '0; have_free = 1'b0; free_idx = '0;
      for (int i = TABLE_ENTRIES-1; i >= 0; i--) begin
         if (valid_ff[i] && eaddr_ff[i] == addr_ff) begin
            hit = 1'b1; hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            have_free = 1'b1; free_idx = IW'(i);
         end
      end
   end

   assign slot_idx = hit ? hit_idx : free_idx;

   // registered slot and new-entry flag between steps
   logic [IW-1:0] slot_ff;
   logic          fresh_ff;
   always_ff @(posedge clock) begin
      if (cmd.global_op) begin
         slot_ff  <= slot_idx;
         fresh_ff <= !hit;
      end
   end

   // client step
   logic [TW-1:0] ctok_cur, cref;
   logic [31:0]   ctime_cur;
   logic [7:0]    cblk_cur, cblk_nx;
   logic          c_ok;
   assign ctok_cur  = fresh_ff ? (TW'(ccap_ff) << FRAC_BITS) : etok_ff[slot_ff];
   assign ctime_cur = fresh_ff ? now_ff : etime_ff[slot_ff];
   assign cblk_cur  = fresh_ff ? 8'd0 : eblk_ff[slot_ff];
   assign cref      = refill(ctok_cur, now_ff - ctime_cur, crate_ff, ccap_ff);
   assign c_ok      = (cref >= ONE);
   assign cblk_nx   = (cblk_cur == 8'hFF) ? cblk_cur : cblk_cur + 8'd1;

   // sweep counter
   logic [IW:0] sw_ff;
   logic [4:0]  rem_ff;
   logic [31:0] idle_el;
   logic        stale;
   assign idle_el = now_ff - etime_ff[sw_ff[IW-1:0]];
   assign stale   = valid_ff[sw_ff[IW-1:0]] && (idle_el > idle_ff);

   always_ff @(posedge clock) begin
      if (cmd.sweep_clr) begin
         sw_ff  <= '0;
         rem_ff <= '0;
      end else if (cmd.sweep) begin
         sw_ff <= sw_ff + 1'b1;
         if (stale && rem_ff != 5'd31) rem_ff <= rem_ff + 5'd1;
      end
   end

   assign sts.is_cleanup = type_ff;
   assign sts.global_ok  = (gref >= ONE);
   assign sts.have_slot  = hit || have_free;
   assign sts.sweep_last = (sw_ff == (IW+1)'(TABLE_ENTRIES - 1));

   // global bucket update
   always_ff @(posedge clock) begin
      if (reset) begin
         gtok_ff  <= TW'(16'd1000) << FRAC_BITS;
         glast_ff <= '0;
      end else if (cmd.global_op) begin
         glast_ff <= now_ff;
         gtok_ff  <= (gref >= ONE) ? gref - ONE : gref;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.client_op) begin
         valid_ff[slot_ff] <= 1'b1;
      end else if (cmd.sweep && stale) begin
         valid_ff[sw_ff[IW-1:0]] <= 1'b0;
      end
   end

   // entry update
   always_ff @(posedge clock) begin
      if (cmd.client_op) begin
         eaddr_ff[slot_ff] <= addr_ff;
         etime_ff[slot_ff] <= now_ff;
         etok_ff[slot_ff]  <= c_ok ? cref - ONE : cref;
         eblk_ff[slot_ff]  <= c_ok ? 8'd0 : cblk_nx;
      end
   end

   // result register
   logic       allowed_ff;
   logic [2:0] status_ff;
   logic [4:0] removed_ff;
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         allowed_ff <= 1'b0;
         removed_ff <= '0;
         if (cmd.sweep) begin
            status_ff  <= ST_CLEANUP;
            removed_ff <= (stale && rem_ff != 5'd31) ? rem_ff + 5'd1 : rem_ff;
         end else if (cmd.client_op) begin
            allowed_ff <= c_ok;
            if (c_ok) status_ff <= ST_ALLOWED;
            else if (cblk_nx > 8'(AGGRESSIVE_LIMIT)) status_ff <= ST_AGGRESSIVE;
            else status_ff <= ST_CLIENT;
         end else if (!sts.global_ok) begin
            status_ff <= ST_GLOBAL;
         end else begin
            status_ff <= ST_FULL;
         end
      end
   end

   assign rsp_allowed       = allowed_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = removed_ff;
endmodule

// File: src/two_level_token_bucket_limiter.sv
// Two-level token bucket limiter, top level.
// Request channel (req_*) carries type, client address and time; stall is driven here.
// Result channel (rsp_*) gives allowed, status and removed count, one per item.
// Configuration writes (csr_*) take a register index and data; ready is always high,
// and writes are to be made only while the block is idle.
// A request has a global step (global refill multiply and table lookup), then a
// client step (client refill multiply and entry update); a global denial or full
// table ends after the global step. A cleanup examines one table entry per cycle,
// the last one only once the output register is free.
// One item is worked on at a time; req_stall is high from acceptance until its
// result is loaded into the output register. The next item is then accepted while
// that result waits.
// If rsp_stall holds the previous result, the block holds its finished work until
// the output register is free.
// Reset (synchronous) restores register defaults, fills the global bucket and
// empties the client table.
// Uses tbl_pkg, tbl_ctrl and tbl_dpath.
`timescale 1ns / 1ps
module two_level_token_bucket_limiter #(
   parameter int TABLE_ENTRIES    = tbl_pkg::TABLE_ENTRIES_DEF,
   parameter int FRAC_BITS        = tbl_pkg::FRAC_BITS_DEF,
   parameter int AGGRESSIVE_LIMIT = tbl_pkg::AGGRESSIVE_LIMIT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_req_type,
   input  logic [31:0]                   req_client_addr,
   input  logic [31:0]                   req_now_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_allowed,
   output logic [2:0]                    rsp_status,
   output logic [4:0]                    rsp_removed_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tbl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbl_pkg::CSR_DAT_W-1:0] csr_data
);
   import tbl_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    rsp_load;

   assign csr_ready = 1'b1;

   tbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .rsp_load  (rsp_load)
   );

   tbl_dpath #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .FRAC_BITS        (FRAC_BITS),
      .AGGRESSIVE_LIMIT (AGGRESSIVE_LIMIT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_req_type      (req_req_type),
      .req_client_addr   (req_client_addr),
      .req_now_time      (req_now_time),
      .cmd               (cmd),
      .rsp_load          (rsp_load),
      .sts               (sts),
      .rsp_allowed       (rsp_allowed),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count)
   );
endmodule

// File: test/tb_top.sv
// Testbench for the two-level token bucket limiter.
// Drives admission and cleanup items, predicts each result and checks it.
// Depends on tbl_pkg and two_level_token_bucket_limiter.
`timescale 1ns / 1ps
module tb_top;
   import tbl_pkg::*;

   localparam int NENT = TABLE_ENTRIES_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam logic REQ_ADMIT = 1'b0;
   localparam logic REQ_SWEEP = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_BAD = 3'd7;  // no register at this index
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_req_type = 1'b0;
   logic [31:0] req_client_addr = '0;
   logic [31:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_allowed;
   logic [2:0] rsp_status;
   logic [4:0] rsp_removed_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   two_level_token_bucket_limiter dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected result of one item
   typedef struct packed {
      logic       allowed;
      logic [2:0] status;
      logic [4:0] removed;
   } verdict_type;

   // stimulus row; chk set where the result is typed in
   typedef struct {
      logic kind;
      logic [31:0] addr;
      logic [31:0] now;
      bit chk;
      verdict_type want;
   } row_type;

   // shadow of configuration and bucket state
   logic [15:0] gcap_q, ccap_q;
   logic [23:0] grate_q, crate_q;
   logic [31:0] idle_q;
   logic [63:0] gtok;
   logic [31:0] glast;
   bit          ent_v[NENT];
   logic [31:0] ent_addr[NENT];
   logic [63:0] ent_tok[NENT];
   logic [31:0] ent_last[NENT];
   logic [7:0]  ent_blk[NENT];

   verdict_type verdicts_due[$];
   int errors = 0;
   int n_checked = 0, n_allowed = 0, n_denied = 0, n_swept = 0;
   int cycles = 0;
   bit rsp_noidle = 1'b0;

   function automatic logic [63:0] topped_up(logic [63:0] tok, logic [31:0] last,
                                             logic [31:0] now, logic [23:0] rate,
                                             logic [15:0] cap);
      logic [63:0] lim, t;
      lim = {48'd0, cap} << FB;
      t = tok + {32'd0, now - last} * {40'd0, rate};
      return (t > lim) ? lim : t;
   endfunction

   function automatic void shadow_reset();
      gcap_q = 16'd1000; grate_q = 24'd65536; ccap_q = 16'd10;
      crate_q = 24'd65536; idle_q = 32'd60000000;
      gtok = {48'd0, gcap_q} << FB;
      glast = '0;
      foreach (ent_v[i]) ent_v[i] = 1'b0;
   endfunction

   function automatic verdict_type police(logic kind, logic [31:0] addr, logic [31:0] now);
      verdict_type v;
      logic [63:0] one;
      int slot, free_slot;
      one = 64'd1 << FB;
      v = '0;
      slot = -1; free_slot = -1;
      if (kind == REQ_SWEEP) begin
         for (int i = 0; i < NENT; i++)
            if (ent_v[i] && (now - ent_last[i]) > idle_q) begin
               ent_v[i] = 1'b0;
               if (v.removed < 31) v.removed++;
            end
         v.status = ST_CLEANUP;
         return v;
      end
      gtok = topped_up(gtok, glast, now, grate_q, gcap_q);
      glast = now;
      if (gtok < one) begin
         v.status = ST_GLOBAL;
         return v;
      end
      gtok -= one;
      for (int i = 0; i < NENT; i++) begin
         if (ent_v[i] && ent_addr[i] == addr) begin
            slot = i;
            break;
         end
         if (!ent_v[i] && free_slot < 0) free_slot = i;
      end
      if (slot < 0 && free_slot >= 0) begin
         slot = free_slot;
         ent_v[slot] = 1'b1; ent_addr[slot] = addr;
         ent_tok[slot] = {48'd0, ccap_q} << FB;
         ent_last[slot] = now; ent_blk[slot] = '0;
      end
      if (slot < 0) begin
         v.status = ST_FULL;
         return v;
      end
      ent_tok[slot] = topped_up(ent_tok[slot], ent_last[slot], now, crate_q, ccap_q);
      ent_last[slot] = now;
      if (ent_tok[slot] >= one) begin
         ent_tok[slot] -= one;
         ent_blk[slot] = '0;
         v.allowed = 1'b1;
         v.status = ST_ALLOWED;
      end else begin
         if (ent_blk[slot] != 8'hFF) ent_blk[slot]++;
         v.status = (ent_blk[slot] > AGGRESSIVE_LIMIT_DEF) ? ST_AGGRESSIVE : ST_CLIENT;
      end
      return v;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t, %0d results outstanding", $time, verdicts_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // result checker and random stall
   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result %b/%0d/%0d", $time,
                     rsp_allowed, rsp_status, rsp_removed_count);
            errors++;
         end else begin
            w = verdicts_due.pop_front();
            n_checked++;
            if (w.status == ST_CLEANUP) n_swept++;
            else if (w.allowed) n_allowed++;
            else n_denied++;
            if (rsp_allowed !== w.allowed) begin
               $display("%0t: allowed expected %b actual %b", $time, w.allowed, rsp_allowed);
               errors++;
            end
            if (rsp_status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $time, w.status, rsp_status);
               errors++;
            end
            if (rsp_removed_count !== w.removed) begin
               $display("%0t: removed_count expected %0d actual %0d", $time,
                        w.removed, rsp_removed_count);
               errors++;
            end
         end
      end
      rsp_stall <= rsp_noidle ? 1'b0 : ($urandom_range(99) < 26);
   end

   // one write, then valid drops and the shadow copy is updated
   task automatic reg_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_GCAP:  gcap_q = val[15:0];
         REG_GRATE: grate_q = val[23:0];
         REG_CCAP:  ccap_q = val[15:0];
         REG_CRATE: crate_q = val[23:0];
         REG_IDLE:  idle_q = val;
         default: ;
      endcase
   endtask

   // wait for every result, then hold the request channel idle before returning
   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (NENT + 8) @(posedge clock);
   endtask

   // valid stays high after acceptance; the caller's next step replaces or drops it
   task automatic send(row_type r, bit idle_ok);
      verdict_type v;
      if (idle_ok)
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_req_type <= r.kind; req_client_addr <= r.addr; req_now_time <= r.now;
      do @(posedge clock); while (req_stall);
      v = police(r.kind, r.addr, r.now);
      if (r.chk && v !== r.want)
         $display("%0t: directed row disagrees, predicted %h typed %h", $time, v, r.want);
      verdicts_due.push_back(r.chk ? r.want : v);
   endtask

   function automatic row_type mk(logic kind, logic [31:0] addr, logic [31:0] now,
                                  bit chk = 0, logic al = 0, logic [2:0] st = ST_ALLOWED,
                                  logic [4:0] rm = 0);
      row_type r;
      r.kind = kind; r.addr = addr; r.now = now; r.chk = chk;
      r.want = '{al, st, rm};
      return r;
   endfunction

   row_type plan[$];
   logic [31:0] clk_now;
   logic [31:0] pool[8];

   initial begin
      row_type r;
      shadow_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: new client, extremes, exhaustion, aggression, stale entry swept
      plan.push_back(mk(REQ_ADMIT, 32'h0, 32'h0, 1, 1, ST_ALLOWED));
      plan.push_back(mk(REQ_ADMIT, 32'hFFFF_FFFF, 32'h0, 1, 1, ST_ALLOWED));
      plan.push_back(mk(REQ_SWEEP, 32'hFFFF_FFFF, 32'h0, 1, 0, ST_CLEANUP, 0));
      for (int i = 0; i < 10; i++) plan.push_back(mk(REQ_ADMIT, 32'h0, 32'h0));
      for (int i = 0; i < 4; i++) plan.push_back(mk(REQ_ADMIT, 32'h0, 32'h0));
      plan.push_back(mk(REQ_ADMIT, 32'h0, 32'hFFFF_FFFF));
      plan.push_back(mk(REQ_SWEEP, 32'h0, 32'hFFFF_FFFF, 1, 0, ST_CLEANUP, 1));
      foreach (plan[i]) send(plan[i], 0);
      drain();

      // fill the table, then an unknown client sees it full; tiny window sweeps all
      reg_write(REG_IDLE, 32'd0);
      for (int i = 0; i < NENT; i++) send(mk(REQ_ADMIT, 32'h100 + i, 32'd5000), 0);
      send(mk(REQ_ADMIT, 32'hDEAD_BEEF, 32'd5000, 1, 0, ST_FULL), 0);
      send(mk(REQ_SWEEP, 0, 32'd5001, 1, 0, ST_CLEANUP, 5'(NENT)), 0);
      drain();

      // zero capacities deny, out-of-range index ignored
      reg_write(REG_GCAP, 32'hFFFF_0000);
      reg_write(REG_GRATE, 32'h0);
      reg_write(REG_BAD, 32'h1234);
      send(mk(REQ_ADMIT, 32'h5, 32'd6000, 1, 0, ST_GLOBAL), 0);
      drain();
      reg_write(REG_GCAP, 32'hFFFF);
      reg_write(REG_GRATE, 32'hFFFF_FFFF);
      reg_write(REG_CCAP, 32'h0);
      send(mk(REQ_ADMIT, 32'h6, 32'd7000, 1, 0, ST_CLIENT), 0);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         reg_write(REG_GCAP, (ph == 0) ? 32'hFFFF : $urandom_range(40));
         reg_write(REG_GRATE, (ph == 1) ? 32'hFF_FFFF : $urandom_range(50000));
         reg_write(REG_CCAP, (ph == 2) ? 32'hFFFF : $urandom_range(6));
         reg_write(REG_CRATE, (ph == 3) ? 32'h0 : $urandom_range(30000));
         reg_write(REG_IDLE, (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(400));
         foreach (pool[i]) pool[i] = (ph == 5 && i > 3) ? $urandom : $urandom_range(20);
         clk_now = $urandom;
         rsp_noidle = (ph == 2);
         for (int k = 0; k < 75; k++) begin
            clk_now += ($urandom_range(9) == 0) ? $urandom : $urandom_range(30);
            if ($urandom_range(11) == 0)
               r = mk(REQ_SWEEP, $urandom, clk_now);
            else if ($urandom_range(5) == 0)
               r = mk(REQ_ADMIT, $urandom, ($urandom_range(19) == 0) ? $urandom : clk_now);
            else
               r = mk(REQ_ADMIT, pool[$urandom_range(7)], clk_now);
            send(r, ph != 2);
         end
         rsp_noidle = 1'b0;
         drain();
      end

      foreach (verdicts_due[i]) errors++;
      $display("checked %0d results across directed rows and six random phases", n_checked);
      $display("admitted %0d, denied %0d, cleanup sweeps %0d", n_allowed, n_denied, n_swept);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
